[src/rdcr_pkg.sv]
`default_nettype none
package rdcr_pkg;

    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 72;
    localparam int CFG_W = 17;
    localparam int SQRT_STEPS = 34;
    localparam int DIV_STEPS = 32;
    localparam logic [32:0] DEV_MAX = 33'h1_FFFF_FFFF;

    localparam logic CFG_BLEND_FRACTION = 1'b0;
    localparam logic CFG_EPSILON = 1'b1;

    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_BLEND = 2'd1,
        FUNC_ENFORCE = 2'd2,
        FUNC_SET = 2'd3
    } func_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_LD_WR, ST_LD_RD, ST_RD_A, ST_RD_B, ST_GOT_B,
        ST_BL_MUL, ST_BL_ADD, ST_BL_WR, ST_DIFF, ST_SQ, ST_SQRT_INIT, ST_SQRT,
        ST_LD_REST, ST_DEV_ROOT, ST_EN_ND, ST_EN_MUL, ST_DIV_INIT, ST_DIV,
        ST_EN_OFF, ST_OFF_DEF, ST_EN_NEW, ST_WR_A, ST_WR_B, ST_SET_WR,
        ST_FIN, ST_FIN_IGN
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_ACCEPT, OP_LD_WR, OP_LD_RD, OP_RD_A, OP_RD_B, OP_GOT_B,
        OP_BL_MUL, OP_BL_ADD, OP_BL_WR, OP_DIFF, OP_SQ, OP_SQRT_INIT, OP_SQRT,
        OP_LD_REST, OP_DEV_ROOT, OP_EN_ND, OP_EN_MUL, OP_DIV_INIT, OP_DIV,
        OP_EN_OFF, OP_OFF_DEF, OP_EN_NEW, OP_WR_A, OP_WR_B, OP_SET_WR, OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic [1:0] axis;
        logic ign;
    } dp_cmd_t;

    typedef struct packed {
        func_t func;
        logic in_range;
        logic hp_ok;
        logic link_ok;
        logic nd_gt_eps;
        logic out_free;
    } dp_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < 36'shF_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[src/rdcr_ctrl.sv]
`default_nettype none
module rdcr_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire rdcr_pkg::dp_stat_t stat,
    output rdcr_pkg::dp_cmd_t       cmd
);

    rdcr_pkg::state_t state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic [5:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rdcr_pkg::ST_IDLE;
            axis_reg <= 2'd0;
            cnt_reg <= 6'd0;
        end else begin
            state_reg <= state_next;
            axis_reg <= axis_next;
            cnt_reg <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        axis_next = axis_reg;
        cnt_next = cnt_reg;
        unique case (state_reg)
            rdcr_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = rdcr_pkg::ST_DECODE;
            end
            rdcr_pkg::ST_DECODE: begin
                if (!stat.in_range) begin
                    state_next = rdcr_pkg::ST_FIN_IGN;
                end else begin
                    unique case (stat.func)
                        rdcr_pkg::FUNC_LOAD: state_next = rdcr_pkg::ST_LD_WR;
                        rdcr_pkg::FUNC_BLEND: state_next = rdcr_pkg::ST_RD_A;
                        rdcr_pkg::FUNC_ENFORCE: begin
                            state_next = stat.link_ok ? rdcr_pkg::ST_RD_A
                                                      : rdcr_pkg::ST_FIN_IGN;
                        end
                        default: begin
                            state_next = stat.link_ok ? rdcr_pkg::ST_SET_WR
                                                      : rdcr_pkg::ST_FIN_IGN;
                        end
                    endcase
                end
            end
            rdcr_pkg::ST_LD_WR: begin
                state_next = stat.hp_ok ? rdcr_pkg::ST_LD_RD : rdcr_pkg::ST_FIN;
            end
            rdcr_pkg::ST_LD_RD: state_next = rdcr_pkg::ST_GOT_B;
            rdcr_pkg::ST_RD_A: state_next = rdcr_pkg::ST_RD_B;
            rdcr_pkg::ST_RD_B: begin
                axis_next = 2'd0;
                state_next = (stat.func == rdcr_pkg::FUNC_BLEND) ? rdcr_pkg::ST_BL_MUL
                                                                 : rdcr_pkg::ST_GOT_B;
            end
            rdcr_pkg::ST_GOT_B: state_next = rdcr_pkg::ST_DIFF;
            rdcr_pkg::ST_BL_MUL: state_next = rdcr_pkg::ST_BL_ADD;
            rdcr_pkg::ST_BL_ADD: begin
                if (axis_reg == 2'd2) begin
                    state_next = rdcr_pkg::ST_BL_WR;
                end else begin
                    axis_next = axis_reg + 2'd1;
                    state_next = rdcr_pkg::ST_BL_MUL;
                end
            end
            rdcr_pkg::ST_BL_WR: state_next = rdcr_pkg::ST_DIFF;
            rdcr_pkg::ST_DIFF: begin
                axis_next = 2'd0;
                state_next = rdcr_pkg::ST_SQ;
            end
            rdcr_pkg::ST_SQ: begin
                if (axis_reg == 2'd3) begin
                    state_next = rdcr_pkg::ST_SQRT_INIT;
                end else begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            rdcr_pkg::ST_SQRT_INIT: begin
                cnt_next = 6'd0;
                state_next = rdcr_pkg::ST_SQRT;
            end
            rdcr_pkg::ST_SQRT: begin
                if (cnt_reg == 6'(rdcr_pkg::SQRT_STEPS - 1)) begin
                    unique case (stat.func)
                        rdcr_pkg::FUNC_LOAD: state_next = rdcr_pkg::ST_LD_REST;
                        rdcr_pkg::FUNC_BLEND: state_next = rdcr_pkg::ST_DEV_ROOT;
                        default: state_next = rdcr_pkg::ST_EN_ND;
                    endcase
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            rdcr_pkg::ST_LD_REST: state_next = rdcr_pkg::ST_FIN;
            rdcr_pkg::ST_DEV_ROOT: state_next = rdcr_pkg::ST_FIN;
            rdcr_pkg::ST_EN_ND: begin
                axis_next = 2'd0;
                state_next = stat.nd_gt_eps ? rdcr_pkg::ST_EN_MUL : rdcr_pkg::ST_OFF_DEF;
            end
            rdcr_pkg::ST_EN_MUL: state_next = rdcr_pkg::ST_DIV_INIT;
            rdcr_pkg::ST_DIV_INIT: begin
                cnt_next = 6'd0;
                state_next = rdcr_pkg::ST_DIV;
            end
            rdcr_pkg::ST_DIV: begin
                if (cnt_reg == 6'(rdcr_pkg::DIV_STEPS - 1)) begin
                    state_next = rdcr_pkg::ST_EN_OFF;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            rdcr_pkg::ST_EN_OFF: begin
                if (axis_reg == 2'd2) begin
                    state_next = rdcr_pkg::ST_EN_NEW;
                end else begin
                    axis_next = axis_reg + 2'd1;
                    state_next = rdcr_pkg::ST_EN_MUL;
                end
            end
            rdcr_pkg::ST_OFF_DEF: state_next = rdcr_pkg::ST_EN_NEW;
            rdcr_pkg::ST_EN_NEW: state_next = rdcr_pkg::ST_WR_A;
            rdcr_pkg::ST_WR_A: state_next = rdcr_pkg::ST_WR_B;
            rdcr_pkg::ST_WR_B: state_next = rdcr_pkg::ST_FIN;
            rdcr_pkg::ST_SET_WR: state_next = rdcr_pkg::ST_FIN;
            rdcr_pkg::ST_FIN, rdcr_pkg::ST_FIN_IGN: begin
                if (stat.out_free) state_next = rdcr_pkg::ST_IDLE;
            end
            default: state_next = rdcr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.op = rdcr_pkg::OP_NONE;
        cmd.axis = axis_reg;
        cmd.ign = 1'b0;
        s_tready = 1'b0;
        unique case (state_reg)
            rdcr_pkg::ST_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid && aresetn) cmd.op = rdcr_pkg::OP_ACCEPT;
            end
            rdcr_pkg::ST_DECODE: cmd.op = rdcr_pkg::OP_NONE;
            rdcr_pkg::ST_LD_WR: cmd.op = rdcr_pkg::OP_LD_WR;
            rdcr_pkg::ST_LD_RD: cmd.op = rdcr_pkg::OP_LD_RD;
            rdcr_pkg::ST_RD_A: cmd.op = rdcr_pkg::OP_RD_A;
            rdcr_pkg::ST_RD_B: cmd.op = rdcr_pkg::OP_RD_B;
            rdcr_pkg::ST_GOT_B: cmd.op = rdcr_pkg::OP_GOT_B;
            rdcr_pkg::ST_BL_MUL: cmd.op = rdcr_pkg::OP_BL_MUL;
            rdcr_pkg::ST_BL_ADD: cmd.op = rdcr_pkg::OP_BL_ADD;
            rdcr_pkg::ST_BL_WR: cmd.op = rdcr_pkg::OP_BL_WR;
            rdcr_pkg::ST_DIFF: cmd.op = rdcr_pkg::OP_DIFF;
            rdcr_pkg::ST_SQ: cmd.op = rdcr_pkg::OP_SQ;
            rdcr_pkg::ST_SQRT_INIT: cmd.op = rdcr_pkg::OP_SQRT_INIT;
            rdcr_pkg::ST_SQRT: cmd.op = rdcr_pkg::OP_SQRT;
            rdcr_pkg::ST_LD_REST: cmd.op = rdcr_pkg::OP_LD_REST;
            rdcr_pkg::ST_DEV_ROOT: cmd.op = rdcr_pkg::OP_DEV_ROOT;
            rdcr_pkg::ST_EN_ND: cmd.op = rdcr_pkg::OP_EN_ND;
            rdcr_pkg::ST_EN_MUL: cmd.op = rdcr_pkg::OP_EN_MUL;
            rdcr_pkg::ST_DIV_INIT: cmd.op = rdcr_pkg::OP_DIV_INIT;
            rdcr_pkg::ST_DIV: cmd.op = rdcr_pkg::OP_DIV;
            rdcr_pkg::ST_EN_OFF: cmd.op = rdcr_pkg::OP_EN_OFF;
            rdcr_pkg::ST_OFF_DEF: cmd.op = rdcr_pkg::OP_OFF_DEF;
            rdcr_pkg::ST_EN_NEW: cmd.op = rdcr_pkg::OP_EN_NEW;
            rdcr_pkg::ST_WR_A: cmd.op = rdcr_pkg::OP_WR_A;
            rdcr_pkg::ST_WR_B: cmd.op = rdcr_pkg::OP_WR_B;
            rdcr_pkg::ST_SET_WR: cmd.op = rdcr_pkg::OP_SET_WR;
            rdcr_pkg::ST_FIN: begin
                if (stat.out_free) cmd.op = rdcr_pkg::OP_RESULT;
            end
            rdcr_pkg::ST_FIN_IGN: begin
                cmd.ign = 1'b1;
                if (stat.out_free) cmd.op = rdcr_pkg::OP_RESULT;
            end
            default: cmd.op = rdcr_pkg::OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

[src/rdcr_dpath.sv]
`default_nettype none
module rdcr_dpath #(
    parameter int MAX_POINTS = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire rdcr_pkg::dp_cmd_t                 cmd,
    output rdcr_pkg::dp_stat_t                     stat,
    input  wire logic [rdcr_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic [1:0]                        s_tuser,
    input  wire logic                              s_tlast,
    input  wire logic                              cfg_wr_en,
    input  wire logic                              cfg_addr,
    input  wire logic [rdcr_pkg::CFG_W-1:0]        cfg_wr_data,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [rdcr_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                   m_tuser,
    output logic                                   m_tlast
);

    localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

    logic [16:0] blend_fraction_reg;
    logic [15:0] epsilon_reg;
    logic [32:0] running_max_reg;
    logic        m_valid_reg;
    logic [MAX_POINTS-1:0] link_valid_reg;

    rdcr_pkg::func_t func_reg;
    logic [AW-1:0] pi_reg, pa_reg;
    logic          in_range_reg, hp_ok_reg, last_reg;
    logic signed [31:0] t_reg [3];
    logic signed [31:0] len_reg;

    logic [95:0]   pt_mem [MAX_POINTS];
    logic [AW-1:0] par_mem [MAX_POINTS];
    logic [31:0]   rest_mem [MAX_POINTS];
    logic [95:0]   pt_q_reg;
    logic [AW-1:0] par_q_reg;
    logic [31:0]   rest_q_reg;

    logic signed [31:0] a_reg [3];
    logic signed [31:0] b_reg [3];
    logic [32:0]        dmag_reg [3];
    logic               dneg_reg [3];
    logic signed [33:0] off_reg [3];
    logic [65:0]        prod_reg;
    logic               bneg_reg;
    logic [67:0]        acc_reg;
    logic [67:0]        rad_reg;
    logic [34:0]        rem_reg;
    logic [33:0]        root_reg;
    logic [33:0]        drem_reg;
    logic [31:0]        dq_reg;
    logic [32:0]        dev_reg;
    logic [32:0]        m_dev_reg, m_pm_reg;
    logic               m_status_reg, m_last_reg;

    logic [5:0]  in_pi, in_pa;
    logic [10:0] in_pi_ext, in_pa_ext;
    logic        in_pi_ok, in_pa_ok;

    logic          pt_rd_en, pt_wr_en;
    logic [AW-1:0] pt_rd_addr, pt_wr_addr;
    logic [95:0]   pt_wr_data;
    logic          rest_wr_en;
    logic [31:0]   rest_wr_data;

    logic signed [31:0] a_sel, t_sel;
    logic [32:0]        dmag_sel;
    logic               dneg_sel;
    logic signed [32:0] bdif;
    logic [32:0]        bmag;
    logic [16:0]        fsat;
    logic [32:0]        mul_a, mul_b;
    logic [33:0]        bq;
    logic signed [35:0] bsum;
    logic [36:0]        sq_sh, sq_trial;
    logic               sq_ge;
    logic [34:0]        dv_sh;
    logic               dv_ge;
    logic signed [33:0] qs;
    logic signed [34:0] err;
    logic [34:0]        err_mag;
    logic [32:0]        pm;
    logic               out_free;
    logic signed [32:0] dif [3];
    logic signed [34:0] sum_p [3], sum_m [3];

    assign in_pi = s_tdata[5:0];
    assign in_pa = s_tdata[12:7];
    assign in_pi_ext = 11'(in_pi);
    assign in_pa_ext = 11'(in_pa);
    assign in_pi_ok = 32'(in_pi) < 32'(MAX_POINTS);
    assign in_pa_ok = 32'(in_pa) < 32'(MAX_POINTS);

    assign out_free = !m_valid_reg || m_tready;

    assign stat.func = func_reg;
    assign stat.in_range = in_range_reg;
    assign stat.hp_ok = hp_ok_reg;
    assign stat.link_ok = link_valid_reg[pi_reg];
    assign stat.nd_gt_eps = root_reg > {18'd0, epsilon_reg};
    assign stat.out_free = out_free;

    always_comb begin
        case (cmd.axis)
            2'd0: begin
                a_sel = a_reg[0];
                t_sel = t_reg[0];
                dmag_sel = dmag_reg[0];
                dneg_sel = dneg_reg[0];
            end
            2'd1: begin
                a_sel = a_reg[1];
                t_sel = t_reg[1];
                dmag_sel = dmag_reg[1];
                dneg_sel = dneg_reg[1];
            end
            default: begin
                a_sel = a_reg[2];
                t_sel = t_reg[2];
                dmag_sel = dmag_reg[2];
                dneg_sel = dneg_reg[2];
            end
        endcase
    end

    always_comb begin
        bdif = {t_sel[31], t_sel} - {a_sel[31], a_sel};
        bmag = bdif[32] ? 33'(-bdif) : 33'(bdif);
        fsat = (blend_fraction_reg[16] && (blend_fraction_reg[15:0] != 16'd0))
             ? 17'h1_0000 : blend_fraction_reg;
        case (cmd.op)
            rdcr_pkg::OP_BL_MUL: begin
                mul_a = 33'(fsat);
                mul_b = bmag;
            end
            rdcr_pkg::OP_EN_MUL: begin
                mul_a = 33'(rest_q_reg);
                mul_b = dmag_sel;
            end
            default: begin
                mul_a = dmag_sel;
                mul_b = dmag_sel;
            end
        endcase
        bq = prod_reg[49:16];
        bsum = bneg_reg ? (36'(a_sel) - $signed({2'b00, bq}))
                        : (36'(a_sel) + $signed({2'b00, bq}));
        sq_sh = {rem_reg, rad_reg[67:66]};
        sq_trial = {1'b0, root_reg, 2'b01};
        sq_ge = sq_sh >= sq_trial;
        dv_sh = {drem_reg, dq_reg[31]};
        dv_ge = dv_sh >= {1'b0, root_reg};
        qs = dneg_sel ? -$signed({2'b00, dq_reg}) : $signed({2'b00, dq_reg});
        err = $signed({1'b0, root_reg}) - $signed({3'b000, rest_q_reg});
        err_mag = err[34] ? 35'(-err) : 35'(err);
        pm = (running_max_reg > dev_reg) ? running_max_reg : dev_reg;
        for (int k = 0; k < 3; k++) begin
            dif[k] = {a_reg[k][31], a_reg[k]} - {b_reg[k][31], b_reg[k]};
            sum_p[k] = 35'(a_reg[k]) + 35'(b_reg[k]) + 35'(off_reg[k]);
            sum_m[k] = 35'(a_reg[k]) + 35'(b_reg[k]) - 35'(off_reg[k]);
        end
    end

    always_comb begin
        pt_rd_en = 1'b0;
        pt_rd_addr = pi_reg;
        pt_wr_en = 1'b0;
        pt_wr_addr = pi_reg;
        pt_wr_data = {t_reg[2], t_reg[1], t_reg[0]};
        rest_wr_en = 1'b0;
        rest_wr_data = (root_reg[33:32] != 2'b00) ? 32'hFFFF_FFFF : root_reg[31:0];
        case (cmd.op)
            rdcr_pkg::OP_RD_A: pt_rd_en = 1'b1;
            rdcr_pkg::OP_RD_B: begin
                pt_rd_en = 1'b1;
                pt_rd_addr = par_q_reg;
            end
            rdcr_pkg::OP_LD_RD: begin
                pt_rd_en = 1'b1;
                pt_rd_addr = pa_reg;
            end
            rdcr_pkg::OP_LD_WR: pt_wr_en = 1'b1;
            rdcr_pkg::OP_BL_WR, rdcr_pkg::OP_WR_A: begin
                pt_wr_en = 1'b1;
                pt_wr_data = (cmd.op == rdcr_pkg::OP_BL_WR)
                           ? {b_reg[2], b_reg[1], b_reg[0]}
                           : {a_reg[2], a_reg[1], a_reg[0]};
            end
            rdcr_pkg::OP_WR_B: begin
                pt_wr_en = 1'b1;
                pt_wr_addr = par_q_reg;
                pt_wr_data = {b_reg[2], b_reg[1], b_reg[0]};
            end
            rdcr_pkg::OP_LD_REST: rest_wr_en = 1'b1;
            rdcr_pkg::OP_SET_WR: begin
                rest_wr_en = 1'b1;
                rest_wr_data = len_reg[31] ? 32'(-len_reg) : 32'(len_reg);
            end
            default: pt_rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pt_wr_en) pt_mem[pt_wr_addr] <= pt_wr_data;
        if (pt_rd_en) pt_q_reg <= pt_mem[pt_rd_addr];
        if (rest_wr_en) rest_mem[pi_reg] <= rest_wr_data;
        if (cmd.op == rdcr_pkg::OP_LD_WR) par_mem[pi_reg] <= pa_reg;
        if (cmd.op == rdcr_pkg::OP_RD_A) begin
            par_q_reg <= par_mem[pi_reg];
            rest_q_reg <= rest_mem[pi_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blend_fraction_reg <= 17'd0;
            epsilon_reg <= 16'd1;
            running_max_reg <= 33'd0;
            m_valid_reg <= 1'b0;
            link_valid_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    rdcr_pkg::CFG_BLEND_FRACTION: blend_fraction_reg <= cfg_wr_data;
                    default: epsilon_reg <= cfg_wr_data[15:0];
                endcase
            end
            if (cmd.op == rdcr_pkg::OP_LD_WR) link_valid_reg[pi_reg] <= hp_ok_reg;
            if (cmd.op == rdcr_pkg::OP_RESULT) begin
                m_valid_reg <= 1'b1;
                running_max_reg <= last_reg ? 33'd0 : pm;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            rdcr_pkg::OP_ACCEPT: begin
                func_reg <= rdcr_pkg::func_t'(s_tuser);
                pi_reg <= in_pi_ext[AW-1:0];
                pa_reg <= in_pa_ext[AW-1:0];
                in_range_reg <= in_pi_ok;
                hp_ok_reg <= s_tdata[6] && in_pa_ok;
                t_reg[0] <= s_tdata[44:13];
                t_reg[1] <= s_tdata[76:45];
                t_reg[2] <= s_tdata[108:77];
                len_reg <= s_tdata[140:109];
                last_reg <= s_tlast;
                dev_reg <= 33'd0;
            end
            rdcr_pkg::OP_LD_WR: begin
                for (int k = 0; k < 3; k++) a_reg[k] <= t_reg[k];
            end
            rdcr_pkg::OP_RD_B: begin
                a_reg[0] <= pt_q_reg[31:0];
                a_reg[1] <= pt_q_reg[63:32];
                a_reg[2] <= pt_q_reg[95:64];
            end
            rdcr_pkg::OP_GOT_B: begin
                b_reg[0] <= pt_q_reg[31:0];
                b_reg[1] <= pt_q_reg[63:32];
                b_reg[2] <= pt_q_reg[95:64];
            end
            rdcr_pkg::OP_BL_MUL: begin
                prod_reg <= mul_a * mul_b;
                bneg_reg <= bdif[32];
            end
            rdcr_pkg::OP_BL_ADD: begin
                for (int k = 0; k < 3; k++) begin
                    if (cmd.axis == 2'(k)) b_reg[k] <= rdcr_pkg::sat32(bsum);
                end
            end
            rdcr_pkg::OP_DIFF: begin
                acc_reg <= 68'd0;
                for (int k = 0; k < 3; k++) begin
                    dmag_reg[k] <= dif[k][32] ? 33'(-dif[k]) : 33'(dif[k]);
                    dneg_reg[k] <= dif[k][32];
                end
            end
            rdcr_pkg::OP_SQ: begin
                if (cmd.axis != 2'd3) prod_reg <= mul_a * mul_b;
                if (cmd.axis != 2'd0) acc_reg <= acc_reg + 68'(prod_reg);
            end
            rdcr_pkg::OP_SQRT_INIT: begin
                rad_reg <= acc_reg;
                rem_reg <= 35'd0;
                root_reg <= 34'd0;
            end
            rdcr_pkg::OP_SQRT: begin
                rad_reg <= {rad_reg[65:0], 2'b00};
                rem_reg <= sq_ge ? 35'(sq_sh - sq_trial) : 35'(sq_sh);
                root_reg <= {root_reg[32:0], sq_ge};
            end
            rdcr_pkg::OP_DEV_ROOT: begin
                dev_reg <= root_reg[33] ? rdcr_pkg::DEV_MAX : root_reg[32:0];
            end
            rdcr_pkg::OP_EN_ND: begin
                dev_reg <= (err_mag[34:33] != 2'b00) ? rdcr_pkg::DEV_MAX : err_mag[32:0];
            end
            rdcr_pkg::OP_EN_MUL: prod_reg <= mul_a * mul_b;
            rdcr_pkg::OP_DIV_INIT: begin
                drem_reg <= 34'(prod_reg[64:32]);
                dq_reg <= prod_reg[31:0];
            end
            rdcr_pkg::OP_DIV: begin
                drem_reg <= dv_ge ? 34'(dv_sh - {1'b0, root_reg}) : dv_sh[33:0];
                dq_reg <= {dq_reg[30:0], dv_ge};
            end
            rdcr_pkg::OP_EN_OFF: begin
                for (int k = 0; k < 3; k++) begin
                    if (cmd.axis == 2'(k)) off_reg[k] <= qs;
                end
            end
            rdcr_pkg::OP_OFF_DEF: begin
                off_reg[0] <= 34'sd0;
                off_reg[1] <= $signed({2'b00, rest_q_reg});
                off_reg[2] <= 34'sd0;
            end
            rdcr_pkg::OP_EN_NEW: begin
                for (int k = 0; k < 3; k++) begin
                    a_reg[k] <= rdcr_pkg::sat32(36'(sum_p[k] >>> 1));
                    b_reg[k] <= rdcr_pkg::sat32(36'(sum_m[k] >>> 1));
                end
            end
            rdcr_pkg::OP_RESULT: begin
                m_dev_reg <= dev_reg;
                m_pm_reg <= pm;
                m_status_reg <= cmd.ign;
                m_last_reg <= last_reg;
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {6'd0, m_pm_reg, m_dev_reg};
    assign m_tuser = m_status_reg;
    assign m_tlast = m_last_reg;

endmodule
`default_nettype wire

[src/ragdoll_distance_constraint_relax.sv]
// Keeps up to MAX_POINTS joint points with parent links and rest lengths, and
// relaxes distance constraints between a point and its parent.
// The input channel takes one item per transfer: tuser is the function code,
// tlast marks the end of a pass, and tdata packs the indices, link flag,
// position and length. The result channel returns one transfer per item with
// the deviation and the running pass maximum in tdata, the ignored flag in
// tuser and the pass marker in tlast.
// Items are processed one at a time by a shared multiplier, a bit-serial
// square root of 34 steps and a bit-serial divider of 32 steps per axis.
// A load without a parent skips the square root, and an enforce item skips the
// divider when the distance is at or below epsilon. A new input is taken as
// soon as the previous item's result sits in the output register; if the
// receiver stalls, the block holds the next result until that register is
// free. Reset clears all links and the running maximum and sets the blend
// fraction to zero and epsilon to one; point positions and rest lengths are
// undefined until written.
`default_nettype none
module ragdoll_distance_constraint_relax #(
    parameter int MAX_POINTS = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // point_index, has_parent, parent_index, pos_x, pos_y, pos_z, length
    input  wire logic [rdcr_pkg::S_TDATA_W-1:0] s_tdata,
    // func
    input  wire logic [1:0]                     s_tuser,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // deviation, pass_max
    output logic [rdcr_pkg::M_TDATA_W-1:0]      m_tdata,
    // status
    output logic                                m_tuser,
    output logic                                m_tlast,
    input  wire logic                           cfg_wr_en,
    input  wire logic                           cfg_addr,
    input  wire logic [rdcr_pkg::CFG_W-1:0]     cfg_wr_data
);

    rdcr_pkg::dp_cmd_t  cmd;
    rdcr_pkg::dp_stat_t stat;

    rdcr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rdcr_dpath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;

    typedef struct {
        rdcr_pkg::func_t   func;
        logic [5:0]        pi;
        logic              hp;
        logic [5:0]        pa;
        logic signed [31:0] x, y, z, len;
        logic              last;
    } joint_item_t;

    typedef struct {
        logic [32:0] dev;
        logic [32:0] pm;
        logic        status;
        logic        last;
    } relax_res_t;

    localparam int WATCHDOG_LIMIT = 5000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [rdcr_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [rdcr_pkg::M_TDATA_W-1:0] m_tdata;
    logic m_tuser;
    logic m_tlast;
    logic cfg_wr_en = 1'b0;
    logic cfg_addr = 1'b0;
    logic [rdcr_pkg::CFG_W-1:0] cfg_wr_data = '0;

    ragdoll_distance_constraint_relax dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Predictor state.
    logic signed [31:0] pos_x [64], pos_y [64], pos_z [64];
    logic        link_ok [64];
    logic [5:0]  link_to [64];
    logic [31:0] rest_len [64];
    logic [32:0] run_max;
    logic [16:0] frac_reg;
    logic [15:0] eps_reg;

    // Stimulus bookkeeping.
    logic        written [64];
    int          written_list [$];
    joint_item_t pending_items [$];
    relax_res_t  expected_results [$];
    int          errors = 0;
    bit          quiet = 1'b0;
    bit          s_fired = 1'b0;
    int          s_gap = 0;
    int          m_gap = 0;
    int          idle_cycles = 0;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] abs64(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [33:0] root_dist(input longint dx, input longint dy,
                                              input longint dz);
        logic [67:0] acc, c2, m;
        logic [33:0] r, c;
        acc = '0;
        m = {4'b0, abs64(dx)}; acc = acc + m * m;
        m = {4'b0, abs64(dy)}; acc = acc + m * m;
        m = {4'b0, abs64(dz)}; acc = acc + m * m;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (34'd1 << b);
            c2 = {34'b0, c} * {34'b0, c};
            if (c2 <= acc) r = c;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] blend_toward(input logic signed [31:0] p,
                                                        input logic signed [31:0] t,
                                                        input logic [63:0] f);
        longint diff;
        logic [63:0] q;
        diff = longint'(t) - longint'(p);
        q = (f * abs64(diff)) >> 16;
        return clamp32(longint'(p) + (diff < 0 ? -longint'(q) : longint'(q)));
    endfunction

    function automatic relax_res_t relax_predict(input joint_item_t it);
        relax_res_t r;
        logic [63:0] dev, f, nd, rest, q;
        longint a [3], b [3], off [3], diff;
        logic [5:0] pb;
        logic signed [31:0] ox, oy, oz;
        dev = 0;
        r.status = 1'b0;
        if (it.func == rdcr_pkg::FUNC_LOAD) begin
            pos_x[it.pi] = it.x; pos_y[it.pi] = it.y; pos_z[it.pi] = it.z;
            if (it.hp) begin
                nd = 64'(root_dist(longint'(it.x) - pos_x[it.pa],
                                   longint'(it.y) - pos_y[it.pa],
                                   longint'(it.z) - pos_z[it.pa]));
                link_ok[it.pi] = 1'b1;
                link_to[it.pi] = it.pa;
                rest_len[it.pi] = nd > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : nd[31:0];
            end else begin
                link_ok[it.pi] = 1'b0;
            end
        end else if (it.func == rdcr_pkg::FUNC_BLEND) begin
            f = frac_reg > 17'd65536 ? 64'd65536 : 64'(frac_reg);
            ox = pos_x[it.pi]; oy = pos_y[it.pi]; oz = pos_z[it.pi];
            pos_x[it.pi] = blend_toward(ox, it.x, f);
            pos_y[it.pi] = blend_toward(oy, it.y, f);
            pos_z[it.pi] = blend_toward(oz, it.z, f);
            dev = 64'(root_dist(longint'(pos_x[it.pi]) - ox, longint'(pos_y[it.pi]) - oy,
                                longint'(pos_z[it.pi]) - oz));
        end else if (!link_ok[it.pi]) begin
            r.status = 1'b1;
        end else if (it.func == rdcr_pkg::FUNC_SET) begin
            rest_len[it.pi] = 32'(abs64(longint'(it.len)));
        end else begin
            pb = link_to[it.pi];
            rest = 64'(rest_len[it.pi]);
            a[0] = pos_x[it.pi]; a[1] = pos_y[it.pi]; a[2] = pos_z[it.pi];
            b[0] = pos_x[pb]; b[1] = pos_y[pb]; b[2] = pos_z[pb];
            nd = 64'(root_dist(a[0] - b[0], a[1] - b[1], a[2] - b[2]));
            for (int k = 0; k < 3; k++) begin
                diff = a[k] - b[k];
                if (nd > 64'(eps_reg)) begin
                    q = (rest * abs64(diff)) / nd;
                    off[k] = diff < 0 ? -longint'(q) : longint'(q);
                end else begin
                    off[k] = (k == 1) ? longint'(rest) : 0;
                end
            end
            pos_x[it.pi] = clamp32((a[0] + b[0] + off[0]) >>> 1);
            pos_y[it.pi] = clamp32((a[1] + b[1] + off[1]) >>> 1);
            pos_z[it.pi] = clamp32((a[2] + b[2] + off[2]) >>> 1);
            pos_x[pb] = clamp32((a[0] + b[0] - off[0]) >>> 1);
            pos_y[pb] = clamp32((a[1] + b[1] - off[1]) >>> 1);
            pos_z[pb] = clamp32((a[2] + b[2] - off[2]) >>> 1);
            dev = nd > rest ? nd - rest : rest - nd;
        end
        if (dev > 64'(rdcr_pkg::DEV_MAX)) dev = 64'(rdcr_pkg::DEV_MAX);
        r.dev = dev[32:0];
        r.pm = run_max > r.dev ? run_max : r.dev;
        run_max = it.last ? '0 : r.pm;
        r.last = it.last;
        return r;
    endfunction

    task automatic push_item(input rdcr_pkg::func_t fn, input int pi, input bit hp,
                             input int pa,
                             input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] z, input logic signed [31:0] len,
                             input bit last);
        joint_item_t it;
        it.func = fn; it.pi = pi[5:0]; it.hp = hp; it.pa = pa[5:0];
        it.x = x; it.y = y; it.z = z; it.len = len; it.last = last;
        if (fn == rdcr_pkg::FUNC_LOAD && !written[pi]) begin
            written[pi] = 1'b1;
            written_list = {written_list, pi};
        end
        pending_items = {pending_items, it};
        expected_results = {expected_results, relax_predict(it)};
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 2097152)) - 32'sd1048576;
            2: return $signed($urandom_range(0, 65536)) - 32'sd32768;
            default: return $signed($urandom_range(0, 33554432)) - 32'sd16777216;
        endcase
    endfunction

    task automatic push_random();
        int r, pi, pa;
        logic signed [31:0] len;
        r = $urandom_range(0, 9);
        len = $urandom;
        if (len == 32'sh8000_0000) len = 32'sh8000_0001;
        pi = written_list[$urandom_range(0, written_list.size() - 1)];
        pa = written_list[$urandom_range(0, written_list.size() - 1)];
        if (r < 3) begin
            pi = $urandom_range(0, 63);
            push_item(rdcr_pkg::FUNC_LOAD, pi, $urandom_range(0, 4) != 0, pa, rand_coord(),
                      rand_coord(), rand_coord(), len, $urandom_range(0, 7) == 0);
        end else if (r < 6) begin
            push_item(rdcr_pkg::FUNC_BLEND, pi, $urandom_range(0, 1), $urandom_range(0, 63),
                      rand_coord(), rand_coord(), rand_coord(), len,
                      $urandom_range(0, 7) == 0);
        end else begin
            if ($urandom_range(0, 9) == 0) pi = $urandom_range(0, 63);
            push_item(r < 9 ? rdcr_pkg::FUNC_ENFORCE : rdcr_pkg::FUNC_SET, pi,
                      $urandom_range(0, 1),
                      $urandom_range(0, 63), $urandom, $urandom, $urandom,
                      r == 9 && $urandom_range(0, 1) ? len >>> $urandom_range(8, 16) : len,
                      $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic write_reg(input logic addr, input logic [rdcr_pkg::CFG_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == rdcr_pkg::CFG_BLEND_FRACTION) frac_reg = value;
        else eps_reg = value[15:0];
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && expected_results.size() == 0);
        repeat (250) @(posedge aclk);
    endtask

    // Input driver and output ready pattern.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !s_fired) begin
                s_tvalid <= 1'b1;
            end else if (s_gap > 0) begin
                s_gap <= s_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0 && !quiet && $urandom_range(0, 7) == 0) begin
                s_gap <= $urandom_range(0, 4);
                s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tuser <= pending_items[0].func;
                s_tlast <= pending_items[0].last;
                s_tdata <= {3'b0, pending_items[0].len, pending_items[0].z,
                            pending_items[0].y, pending_items[0].x, pending_items[0].pa,
                            pending_items[0].hp, pending_items[0].pi};
            end else begin
                s_tvalid <= 1'b0;
            end
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_gap <= $urandom_range(0, 4);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Monitor, scoreboard and watchdog.
    always @(posedge aclk) begin
        relax_res_t e;
        s_fired <= s_tvalid && s_tready;
        if (s_tvalid && s_tready) void'(pending_items.pop_front());
        if (m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result dev=%h max=%h status=%b last=%b", $time,
                         m_tdata[32:0], m_tdata[65:33], m_tuser, m_tlast);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (m_tdata[32:0] !== e.dev) begin
                    $display("%0t: deviation expected %h actual %h", $time, e.dev,
                             m_tdata[32:0]);
                    errors++;
                end
                if (m_tdata[65:33] !== e.pm) begin
                    $display("%0t: pass_max expected %h actual %h", $time, e.pm,
                             m_tdata[65:33]);
                    errors++;
                end
                if (m_tuser !== e.status) begin
                    $display("%0t: status expected %b actual %b", $time, e.status, m_tuser);
                    errors++;
                end
                if (m_tlast !== e.last) begin
                    $display("%0t: last expected %b actual %b", $time, e.last, m_tlast);
                    errors++;
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < 64; i++) begin
            pos_x[i] = 0; pos_y[i] = 0; pos_z[i] = 0;
            link_ok[i] = 1'b0; link_to[i] = 0; rest_len[i] = 0; written[i] = 1'b0;
        end
        run_max = '0;
        frac_reg = '0;
        eps_reg = 16'd1;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_reg(rdcr_pkg::CFG_BLEND_FRACTION, 17'd32768);
        push_item(rdcr_pkg::FUNC_SET, 5, 0, 0, 0, 0, 0, 32'sd100, 0);
        push_item(rdcr_pkg::FUNC_ENFORCE, 5, 1, 63, 0, 0, 0, 0, 0);
        push_item(rdcr_pkg::FUNC_LOAD, 0, 0, 63, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh8000_0000, 32'sh7FFF_FFFF, 0);
        push_item(rdcr_pkg::FUNC_LOAD, 63, 1, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh7FFF_FFFF, -32'sd2147483647, 0);
        push_item(rdcr_pkg::FUNC_ENFORCE, 63, 0, 0, 0, 0, 0, 0, 0);
        push_item(rdcr_pkg::FUNC_LOAD, 1, 1, 0, 32'sh0001_0000, 32'sh8000_0000, 0, 0, 0);
        push_item(rdcr_pkg::FUNC_BLEND, 1, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh8000_0000, 0, 0);
        push_item(rdcr_pkg::FUNC_SET, 1, 0, 0, 0, 0, 0, -32'sd2147483647, 0);
        push_item(rdcr_pkg::FUNC_ENFORCE, 1, 0, 0, 0, 0, 0, 0, 1);
        push_item(rdcr_pkg::FUNC_LOAD, 2, 1, 2, 32'sd500, 32'sd500, 32'sd500, 0, 0);
        push_item(rdcr_pkg::FUNC_SET, 2, 0, 0, 0, 0, 0, 32'sh0002_0000, 0);
        push_item(rdcr_pkg::FUNC_ENFORCE, 2, 0, 0, 0, 0, 0, 0, 0);
        push_item(rdcr_pkg::FUNC_LOAD, 3, 1, 2, 32'sd500, 32'sd500, 32'sd500, 0, 0);
        push_item(rdcr_pkg::FUNC_SET, 3, 0, 0, 0, 0, 0, 32'sh0003_0000, 0);
        push_item(rdcr_pkg::FUNC_ENFORCE, 3, 0, 0, 0, 0, 0, 0, 0);
        push_item(rdcr_pkg::FUNC_LOAD, 10, 1, 1, 32'sh0005_0000, -32'sh0003_0000,
                  32'sh0001_8000, 0, 0);
        push_item(rdcr_pkg::FUNC_LOAD, 4, 1, 10, 32'sd0, 32'sd0, 32'sd0, 0, 0);
        push_item(rdcr_pkg::FUNC_ENFORCE, 10, 0, 0, 0, 0, 0, 0, 0);
        push_item(rdcr_pkg::FUNC_ENFORCE, 4, 0, 0, 0, 0, 0, 0, 0);
        push_item(rdcr_pkg::FUNC_LOAD, 4, 0, 10, 32'sd7, 32'sd7, 32'sd7, 0, 0);
        push_item(rdcr_pkg::FUNC_SET, 4, 0, 0, 0, 0, 0, 32'sd9, 1);
        for (int i = 5; i < 20; i++)
            push_item(rdcr_pkg::FUNC_LOAD, i, 1, i - 1, rand_coord(), rand_coord(),
                      rand_coord(), 0, 0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(rdcr_pkg::CFG_BLEND_FRACTION, 17'd65536);
                         write_reg(rdcr_pkg::CFG_EPSILON, 17'd0); end
                1: begin write_reg(rdcr_pkg::CFG_BLEND_FRACTION, 17'd0);
                         write_reg(rdcr_pkg::CFG_EPSILON, 17'd65535); end
                2: begin write_reg(rdcr_pkg::CFG_BLEND_FRACTION, 17'h1FFFF);
                         write_reg(rdcr_pkg::CFG_EPSILON, 17'd100); end
                3: begin write_reg(rdcr_pkg::CFG_BLEND_FRACTION, 17'd1);
                         write_reg(rdcr_pkg::CFG_EPSILON, 17'd1); end
                4: begin write_reg(rdcr_pkg::CFG_BLEND_FRACTION, 17'd40000);
                         write_reg(rdcr_pkg::CFG_EPSILON, 17'd4096); end
                default: begin
                    write_reg(rdcr_pkg::CFG_BLEND_FRACTION, 17'($urandom_range(0, 65536)));
                    write_reg(rdcr_pkg::CFG_EPSILON, 17'($urandom_range(0, 65535)));
                end
            endcase
            quiet = (ph == 5);
            for (int n = 0; n < 300; n++) push_random();
            drain();
        end

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
